// ===== hw/rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// shared types, phase codes and character class helpers for the automatic
// semicolon detector
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int PHASE_W = 4;
    localparam int KW_W    = 4;
    localparam int CP_W    = 21;

    // scan phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_WS    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NL    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DOT   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PLUS  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_MINUS = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BANG  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_I     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_IN    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_KW    = 4'd9;

    // length of the "stanceof" tail
    localparam logic [KW_W-1:0] KW_LEN = 4'd8;

    localparam logic [CP_W-1:0] CP_EOI  = 21'h000000;
    localparam logic [CP_W-1:0] CP_LF   = 21'h00000A;
    localparam logic [CP_W-1:0] CP_LSEP = 21'h002028;
    localparam logic [CP_W-1:0] CP_PSEP = 21'h002029;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [KW_W-1:0]    kw_idx;
    } t_scan_state;

    typedef struct packed {
        logic valid;
        logic value;
    } t_decision;

    function automatic logic [CP_W-1:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "s";
            3'd1:    ch = "t";
            3'd2:    ch = "a";
            3'd3:    ch = "n";
            3'd4:    ch = "c";
            3'd5:    ch = "e";
            3'd6:    ch = "o";
            default: ch = "f";
        endcase
        return {13'd0, ch};
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        return (c == 21'd32) || (c >= 21'd9 && c <= 21'd13);
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return (c >= 21'd48) && (c <= 21'd57);
    endfunction

    function automatic logic is_alpha(input logic [CP_W-1:0] c);
        return (c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90);
    endfunction

    // characters that continue an expression across a line break
    function automatic logic is_blocker(input logic [CP_W-1:0] c);
        logic hit;
        case (c)
            21'd96, 21'd44, 21'd58, 21'd59, 21'd42, 21'd37,
            21'd62, 21'd60, 21'd61, 21'd91, 21'd40, 21'd63,
            21'd94, 21'd124, 21'd38, 21'd47: hit = 1'b1;
            default:                          hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== hw/rtl/auto_semicolon_detector.sv =====
// ----------------------------------------------------------------------------
// auto_semicolon_detector
// decides per scan whether a zero-length automatic semicolon is inserted
// ----------------------------------------------------------------------------
// One code point is taken per beat, one beat per clock when the result side
// keeps up. A beat lands in an input register; once the result slot is free
// it passes through the character classifier, updates the scan phase and, on
// the beat that decides a scan, loads the result register, which drives the
// result channel. The rate is set by the phase/keyword-index update. A scan
// opens on a beat with start_scan high; exactly one result is given per scan,
// and beats outside a scan give none.
// ----------------------------------------------------------------------------
module auto_semicolon_detector (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [asd_pkg::CP_W-1:0]  i_code_point,
    input  logic                      i_start_scan,
    input  logic                      i_asi_wanted,
    input  logic                      i_range_start,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_insert_semicolon
);

    // input register
    logic                      r_in_valid;
    logic [asd_pkg::CP_W-1:0]  r_code_point;
    logic                      r_start_scan;
    logic                      r_asi_wanted;
    logic                      r_range_start;

    // scan state
    asd_pkg::t_scan_state      r_state;
    asd_pkg::t_scan_state      n_state;
    asd_pkg::t_decision        w_decision;

    // result register
    logic                      r_out_valid;
    logic                      r_out_bit;

    logic                      w_out_free;
    logic                      w_step;
    logic                      w_in_take;

    // the held beat can be processed when the result slot is empty or draining
    assign w_out_free = !r_out_valid || i_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_step;
    assign w_in_take  = i_valid && o_ready;

    asd_classify u_classify (
        .i_state       (r_state),
        .i_code_point  (r_code_point),
        .i_start_scan  (r_start_scan),
        .i_asi_wanted  (r_asi_wanted),
        .i_range_start (r_range_start),
        .o_state       (n_state),
        .o_decision    (w_decision)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_code_point  <= i_code_point;
            r_start_scan  <= i_start_scan;
            r_asi_wanted  <= i_asi_wanted;
            r_range_start <= i_range_start;
        end
    end

    // scan phase advances once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= asd_pkg::PH_IDLE;
            r_state.kw_idx <= '0;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_decision.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_decision.valid) begin
            r_out_bit <= w_decision.value;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_insert_semicolon = r_out_bit;

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_step)
        else $error("result overwritten while stalled");

    // keyword index only moves inside the keyword phase
    a_kw_idx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.kw_idx != '0) |-> (r_state.phase == asd_pkg::PH_KW))
        else $error("keyword index set outside keyword phase");

    // keyword index never passes the tail length
    a_kw_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.kw_idx <= asd_pkg::KW_LEN)
        else $error("keyword index out of range");

    // a deciding beat always returns the scan to idle
    a_decide_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_decision.valid) |=> (r_state.phase == asd_pkg::PH_IDLE))
        else $error("scan not closed after decision");

endmodule

// ===== hw/rtl/asd_classify.sv =====
// ----------------------------------------------------------------------------
// asd_classify
// next scan state and decision for one lookahead character
// ----------------------------------------------------------------------------
module asd_classify (
    input  asd_pkg::t_scan_state       i_state,
    input  logic [asd_pkg::CP_W-1:0]   i_code_point,
    input  logic                       i_start_scan,
    input  logic                       i_asi_wanted,
    input  logic                       i_range_start,
    output asd_pkg::t_scan_state       o_state,
    output asd_pkg::t_decision         o_decision
);

    asd_pkg::t_scan_state s;
    logic [asd_pkg::CP_W-1:0] c;
    logic dec_v;
    logic dec_b;

    assign c = i_code_point;

    always_comb begin
        s      = i_state;
        dec_v  = 1'b0;
        dec_b  = 1'b0;
        o_state = i_state;

        if (i_start_scan) begin
            s.kw_idx = '0;
            s.phase  = asd_pkg::PH_WS;
        end

        if (i_start_scan && !i_asi_wanted) begin
            // not wanted: report no insertion, end the scan
            dec_v = 1'b1;
            dec_b = 1'b0;
            o_state.phase  = asd_pkg::PH_IDLE;
            o_state.kw_idx = '0;
        end else begin
            unique case (s.phase)
                asd_pkg::PH_WS: begin
                    if (c == asd_pkg::CP_EOI || c == 21'd125 || i_range_start) begin
                        dec_v = 1'b1; dec_b = 1'b1;
                    end else if (c == asd_pkg::CP_LF || c == asd_pkg::CP_LSEP ||
                                 c == asd_pkg::CP_PSEP) begin
                        s.phase = asd_pkg::PH_NL;
                    end else if (!asd_pkg::is_space(c)) begin
                        dec_v = 1'b1; dec_b = 1'b0;
                    end
                end
                asd_pkg::PH_NL: begin
                    if (asd_pkg::is_blocker(c)) begin
                        dec_v = 1'b1; dec_b = 1'b0;
                    end else if (c == 21'd46) begin
                        s.phase = asd_pkg::PH_DOT;
                    end else if (c == 21'd43) begin
                        s.phase = asd_pkg::PH_PLUS;
                    end else if (c == 21'd45) begin
                        s.phase = asd_pkg::PH_MINUS;
                    end else if (c == 21'd33) begin
                        s.phase = asd_pkg::PH_BANG;
                    end else if (c == 21'd105) begin
                        s.phase = asd_pkg::PH_I;
                    end else begin
                        dec_v = 1'b1; dec_b = 1'b1;
                    end
                end
                asd_pkg::PH_DOT: begin
                    dec_v = 1'b1; dec_b = asd_pkg::is_digit(c);
                end
                asd_pkg::PH_PLUS: begin
                    dec_v = 1'b1; dec_b = (c == 21'd43);
                end
                asd_pkg::PH_MINUS: begin
                    dec_v = 1'b1; dec_b = (c == 21'd45);
                end
                asd_pkg::PH_BANG: begin
                    dec_v = 1'b1; dec_b = (c != 21'd61);
                end
                asd_pkg::PH_I: begin
                    if (c != 21'd110) begin
                        dec_v = 1'b1; dec_b = 1'b1;
                    end else begin
                        s.phase = asd_pkg::PH_IN;
                    end
                end
                asd_pkg::PH_IN: begin
                    if (!asd_pkg::is_alpha(c)) begin
                        dec_v = 1'b1; dec_b = 1'b0;
                    end else if (c != asd_pkg::kw_char(3'd0)) begin
                        dec_v = 1'b1; dec_b = 1'b1;
                    end else begin
                        s.kw_idx = 4'd1;
                        s.phase  = asd_pkg::PH_KW;
                    end
                end
                asd_pkg::PH_KW: begin
                    if (s.kw_idx >= asd_pkg::KW_LEN) begin
                        dec_v = 1'b1; dec_b = asd_pkg::is_alpha(c);
                    end else if (c != asd_pkg::kw_char(s.kw_idx[2:0])) begin
                        dec_v = 1'b1; dec_b = 1'b1;
                    end else begin
                        s.kw_idx = s.kw_idx + 4'd1;
                    end
                end
                default: begin
                    // idle or unused code: no scan, no result
                    s.phase = asd_pkg::PH_IDLE;
                end
            endcase

            if (dec_v) begin
                o_state.phase  = asd_pkg::PH_IDLE;
                o_state.kw_idx = '0;
            end else begin
                o_state = s;
            end
        end
    end

    assign o_decision.valid = dec_v;
    assign o_decision.value = dec_b;

endmodule
